// ----- sv/tbcsm_pkg.sv -----
package tbcsm_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHORD_WINDOW = 3'd0,
        CFG_REPEAT       = 3'd1,
        CFG_EXIT_HOLD    = 3'd2,
        CFG_LOCKOUT      = 3'd3,
        CFG_INIT_GAIN    = 3'd4,
        CFG_INIT_NOISE   = 3'd5,
        CFG_INIT_AVG     = 3'd6,
        CFG_INIT_FFT     = 3'd7
    } t_cfg_idx;

    // Selected setting codes
    localparam logic [1:0] SEL_GAIN  = 2'd0;
    localparam logic [1:0] SEL_NOISE = 2'd1;
    localparam logic [1:0] SEL_AVG   = 2'd2;
    localparam logic [1:0] SEL_FFT   = 2'd3;

    localparam logic [3:0]  GAIN_MAX   = 4'd8;
    localparam logic [15:0] NOISE_STEP = 16'd50;
    localparam logic [15:0] NOISE_MAX  = 16'd20000;
    localparam logic [6:0]  AVG_MAX    = 7'd100;
    localparam logic [6:0]  AVG_MIN    = 7'd1;
    localparam logic [31:0] FFT_BASE   = 32'd4096;

    typedef struct packed {
        logic [3:0]  gain_lvl;
        logic [7:0]  gain_code;
        logic [14:0] noise;
        logic [6:0]  avg;
        logic [2:0]  fft_idx;
        logic        gain_mod;
    } t_settings;

    typedef struct packed {
        logic run;   // evaluate the button this poll
        logic clr;   // drop pending and repeat state
    } t_tmr_ctl;

endpackage

// ----- sv/two_button_chord_settings_menu.sv -----
// Channel   Direction  Handshake             Contents
// in        sink       i_in_valid/o_in_stall  begin, start/reset pressed, now_ms
// out       source     o_out_valid/i_out_stall selected setting and all values, done
// cfg       sink       i_cfg_valid/o_cfg_ready register index and write data
//
// One poll per cycle while the result is not stalled; a poll passes the input
// register, then the result register with the session state beside it.
// Reset (synchronous, active low) restores register defaults, closes the session.
// A stalled result holds the result register and the input register; the input
// side stalls only while both are full. The cfg port is always ready.
module two_button_chord_settings_menu #(
    parameter int FFT_OPTION_COUNT = 5,
    parameter int PARAM_TOTAL      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_begin_req,
    input  logic        i_start_pressed,
    input  logic        i_reset_pressed,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_param_sel,
    output logic [3:0]  o_gain_lvl,
    output logic [7:0]  o_gain_code,
    output logic [14:0] o_noise_tenths,
    output logic [6:0]  o_avg_count,
    output logic [16:0] o_fft_points,
    output logic        o_gain_changed,
    output logic        o_done_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam logic [1:0] SelLast = 2'(PARAM_TOTAL - 1);
    localparam logic [2:0] FftLast = 3'(FFT_OPTION_COUNT - 1);

    // configuration
    logic [15:0] r_chord_ms, r_repeat_ms, r_exit_ms, r_lock_ms;
    logic [7:0]  r_init_gain;
    logic [14:0] r_init_noise;
    logic [6:0]  r_init_avg;
    logic [16:0] r_init_fft;

    // input register
    logic        r_s1_valid;
    logic        r_s1_begin, r_s1_dec, r_s1_inc;
    logic [31:0] r_s1_now;

    // session state
    logic                 r_session_on, n_session_on;
    logic [1:0]           r_sel, n_sel;
    tbcsm_pkg::t_settings r_set, n_set, adj_set, load_set;
    logic                 r_combo, n_combo;
    logic [31:0]          r_combo_since, n_combo_since;
    logic                 r_lockout_on, n_lockout_on;
    logic [31:0]          r_lock_since, n_lock_since;

    // result register
    logic                 r_out_valid;
    logic [1:0]           r_out_sel;
    tbcsm_pkg::t_settings r_out_set;
    logic                 r_out_done;

    logic                 adv, accept, proc;
    logic                 done, locked;
    tbcsm_pkg::t_tmr_ctl  ctl_c, tmr_ctl;
    logic                 inc_fire, dec_fire;
    logic [2:0]           load_fft_idx;
    logic [31:0]          fft_wide;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign proc       = r_s1_valid && adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord_ms   <= 16'd180;
            r_repeat_ms  <= 16'd200;
            r_exit_ms    <= 16'd1500;
            r_lock_ms    <= 16'd2000;
            r_init_gain  <= 8'd0;
            r_init_noise <= 15'd1000;
            r_init_avg   <= 7'd4;
            r_init_fft   <= 17'd65536;
        end else if (i_cfg_valid) begin
            unique case (tbcsm_pkg::t_cfg_idx'(i_cfg_index))
                tbcsm_pkg::CFG_CHORD_WINDOW: r_chord_ms   <= i_cfg_data[15:0];
                tbcsm_pkg::CFG_REPEAT:       r_repeat_ms  <= i_cfg_data[15:0];
                tbcsm_pkg::CFG_EXIT_HOLD:    r_exit_ms    <= i_cfg_data[15:0];
                tbcsm_pkg::CFG_LOCKOUT:      r_lock_ms    <= i_cfg_data[15:0];
                tbcsm_pkg::CFG_INIT_GAIN:    r_init_gain  <= i_cfg_data[7:0];
                tbcsm_pkg::CFG_INIT_NOISE:   r_init_noise <= i_cfg_data[14:0];
                tbcsm_pkg::CFG_INIT_AVG:     r_init_avg   <= i_cfg_data[6:0];
                tbcsm_pkg::CFG_INIT_FFT:     r_init_fft   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // map the initial FFT size to an option; lowest match wins, unknown gives the last
    always_comb begin
        load_fft_idx = FftLast;
        for (int i = FFT_OPTION_COUNT - 1; i >= 0; i--) begin
            if ((tbcsm_pkg::FFT_BASE << i) == {15'b0, r_init_fft}) begin
                load_fft_idx = 3'(i);
            end
        end
    end

    always_comb begin
        load_set.gain_lvl  = (r_init_gain[3:0] > tbcsm_pkg::GAIN_MAX)
                           ? tbcsm_pkg::GAIN_MAX : r_init_gain[3:0];
        load_set.gain_code = r_init_gain;
        load_set.noise     = r_init_noise;
        load_set.avg       = r_init_avg;
        load_set.fft_idx   = load_fft_idx;
        load_set.gain_mod  = 1'b0;
    end

    always_comb begin
        n_session_on  = r_session_on;
        n_sel         = r_sel;
        n_combo       = r_combo;
        n_combo_since = r_combo_since;
        n_lockout_on  = r_lockout_on;
        n_lock_since  = r_lock_since;
        done          = 1'b0;
        locked        = 1'b0;
        ctl_c         = '0;
        if (r_s1_begin) begin
            n_sel        = tbcsm_pkg::SEL_GAIN;
            n_combo      = 1'b0;
            n_lockout_on = 1'b0;
            ctl_c.clr    = 1'b1;
            n_session_on = 1'b1;
        end else if (r_session_on) begin
            locked = r_lockout_on && ((r_s1_now - r_lock_since) < {16'b0, r_lock_ms});
            if (r_lockout_on && !locked) n_lockout_on = 1'b0;
            if (locked) begin
                // ignore buttons
            end else if (r_s1_inc && r_s1_dec) begin
                ctl_c.clr = 1'b1;
                if (!r_combo) begin
                    n_combo       = 1'b1;
                    n_combo_since = r_s1_now;
                end else if ((r_s1_now - r_combo_since) >= {16'b0, r_exit_ms}) begin
                    done         = 1'b1;
                    n_session_on = 1'b0;
                    n_combo      = 1'b0;
                    n_lockout_on = 1'b0;
                end
            end else if (r_combo) begin
                // short chord released: next setting, then lock out
                n_combo      = 1'b0;
                n_sel        = (r_sel == SelLast) ? 2'd0 : r_sel + 2'd1;
                n_lockout_on = 1'b1;
                n_lock_since = r_s1_now;
            end else begin
                ctl_c.run = 1'b1;
            end
        end
    end

    assign tmr_ctl = proc ? ctl_c : '0;

    tbcsm_hold_timer u_inc_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tmr_ctl),
        .i_held      (r_s1_inc),
        .i_now       (r_s1_now),
        .i_wait_ms   (r_chord_ms),
        .i_repeat_ms (r_repeat_ms),
        .o_fire      (inc_fire)
    );

    tbcsm_hold_timer u_dec_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tmr_ctl),
        .i_held      (r_s1_dec),
        .i_now       (r_s1_now),
        .i_wait_ms   (r_chord_ms),
        .i_repeat_ms (r_repeat_ms),
        .o_fire      (dec_fire)
    );

    // only one button can be held when the timers run, so at most one fires
    tbcsm_adjust #(
        .FFT_OPTION_COUNT (FFT_OPTION_COUNT)
    ) u_adjust (
        .i_sel (r_sel),
        .i_up  (inc_fire),
        .i_set (r_set),
        .o_set (adj_set)
    );

    always_comb begin
        if (r_s1_begin) begin
            n_set = load_set;
        end else if (inc_fire || dec_fire) begin
            n_set = adj_set;
        end else begin
            n_set = r_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_session_on <= 1'b0;
            r_sel        <= tbcsm_pkg::SEL_GAIN;
            r_set        <= '{gain_lvl: 4'd0, gain_code: 8'd0, noise: 15'd0,
                              avg: 7'd4, fft_idx: 3'd4, gain_mod: 1'b0};
            r_combo      <= 1'b0;
            r_lockout_on <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) r_out_valid <= r_s1_valid;
            if (proc) begin
                r_session_on <= n_session_on;
                r_sel        <= n_sel;
                r_set        <= n_set;
                r_combo      <= n_combo;
                r_lockout_on <= n_lockout_on;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_begin <= i_begin_req;
            r_s1_dec   <= i_start_pressed;
            r_s1_inc   <= i_reset_pressed;
            r_s1_now   <= i_now_ms;
        end
        if (proc) begin
            r_combo_since <= n_combo_since;
            r_lock_since  <= n_lock_since;
            r_out_sel     <= n_sel;
            r_out_set     <= n_set;
            r_out_done    <= done;
        end
    end

    assign fft_wide = tbcsm_pkg::FFT_BASE << r_out_set.fft_idx;

    assign o_out_valid    = r_out_valid;
    assign o_param_sel    = r_out_sel;
    assign o_gain_lvl     = r_out_set.gain_lvl;
    assign o_gain_code    = r_out_set.gain_code;
    assign o_noise_tenths = r_out_set.noise;
    assign o_avg_count    = r_out_set.avg;
    assign o_fft_points   = fft_wide[16:0];
    assign o_gain_changed = r_out_set.gain_mod;
    assign o_done_res     = r_out_done;

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> !r_session_on)
        else $error("session still open after an exit result");

    a_lock_in_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lockout_on |-> r_session_on)
        else $error("lockout active outside a session");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_gain_lvl <= tbcsm_pkg::GAIN_MAX)
        else $error("gain step beyond its limit");

    a_begin_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_s1_begin |=> r_session_on && !r_combo && !r_lockout_on)
        else $error("begin request did not open a clean session");

endmodule

// ----- sv/tbcsm_hold_timer.sv -----
module tbcsm_hold_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbcsm_pkg::t_tmr_ctl i_ctl,
    input  logic                i_held,
    input  logic [31:0]         i_now,
    input  logic [15:0]         i_wait_ms,
    input  logic [15:0]         i_repeat_ms,
    output logic                o_fire
);

    logic        r_pend, r_act;
    logic [31:0] r_since, r_last;
    logic        n_pend, n_act;
    logic [31:0] n_since, n_last;
    logic [31:0] wait_dt, rep_dt;

    assign wait_dt = i_now - r_since;
    assign rep_dt  = i_now - r_last;

    always_comb begin
        n_pend  = r_pend;
        n_act   = r_act;
        n_since = r_since;
        n_last  = r_last;
        o_fire  = 1'b0;
        if (i_ctl.clr) begin
            n_pend = 1'b0;
            n_act  = 1'b0;
        end else if (i_ctl.run) begin
            if (!i_held) begin
                n_pend = 1'b0;
                n_act  = 1'b0;
            end else if (!r_pend && !r_act) begin
                n_pend  = 1'b1;
                n_since = i_now;
            end else if (r_pend && wait_dt >= {16'b0, i_wait_ms}) begin
                n_pend = 1'b0;
                n_act  = 1'b1;
                n_last = i_now;
                o_fire = 1'b1;
            end else if (r_act && rep_dt > {16'b0, i_repeat_ms}) begin
                n_last = i_now;
                o_fire = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_act  <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_act  <= n_act;
        end
        r_since <= n_since;
        r_last  <= n_last;
    end

endmodule

// ----- sv/tbcsm_adjust.sv -----
module tbcsm_adjust #(
    parameter int FFT_OPTION_COUNT = 5
) (
    input  logic                 [1:0] i_sel,
    input  logic                       i_up,
    input  tbcsm_pkg::t_settings       i_set,
    output tbcsm_pkg::t_settings       o_set
);

    localparam logic [2:0] FftLast = 3'(FFT_OPTION_COUNT - 1);

    logic [15:0] noise_up;

    assign noise_up = {1'b0, i_set.noise} + tbcsm_pkg::NOISE_STEP;

    always_comb begin
        o_set = i_set;
        unique case (i_sel)
            tbcsm_pkg::SEL_GAIN: begin
                if (i_up) begin
                    if (i_set.gain_lvl < tbcsm_pkg::GAIN_MAX) begin
                        o_set.gain_lvl = i_set.gain_lvl + 4'd1;
                    end
                end else if (i_set.gain_lvl != 4'd0) begin
                    o_set.gain_lvl = i_set.gain_lvl - 4'd1;
                end
                o_set.gain_code = {o_set.gain_lvl, o_set.gain_lvl};
                o_set.gain_mod  = 1'b1;
            end
            tbcsm_pkg::SEL_NOISE: begin
                if (i_up) begin
                    o_set.noise = (noise_up > tbcsm_pkg::NOISE_MAX)
                                ? tbcsm_pkg::NOISE_MAX[14:0] : noise_up[14:0];
                end else if ({1'b0, i_set.noise} < tbcsm_pkg::NOISE_STEP) begin
                    o_set.noise = 15'd0;
                end else begin
                    o_set.noise = i_set.noise - tbcsm_pkg::NOISE_STEP[14:0];
                end
            end
            tbcsm_pkg::SEL_AVG: begin
                if (i_up) begin
                    if (i_set.avg < tbcsm_pkg::AVG_MAX) o_set.avg = i_set.avg + 7'd1;
                end else if (i_set.avg > tbcsm_pkg::AVG_MIN) begin
                    o_set.avg = i_set.avg - 7'd1;
                end
            end
            tbcsm_pkg::SEL_FFT: begin
                if (i_up) begin
                    if (i_set.fft_idx < FftLast) o_set.fft_idx = i_set.fft_idx + 3'd1;
                end else if (i_set.fft_idx != 3'd0) begin
                    o_set.fft_idx = i_set.fft_idx - 3'd1;
                end
            end
            default: o_set = i_set;
        endcase
    end

endmodule
